// ===== design/chtlp_pkg.sv =====
package chtlp_pkg;

  localparam int SLOTS_DEFAULT = 1024;

  localparam int FUNC_W   = 2;
  localparam int COORD_W  = 16;
  localparam int ID_W     = 16;
  localparam int KEY_W    = 3 * COORD_W;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 10;
  localparam int TOTAL_W  = 11;

  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  localparam logic [31:0] HASH_MUL_X = 32'd9;
  localparam logic [31:0] HASH_MUL_Y = 32'd37;
  localparam logic [31:0] HASH_MUL_Z = 32'd149;

endpackage

// ===== design/chtlp_req_if.sv =====
interface chtlp_req_if import chtlp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [FUNC_W-1:0]          func;
  logic signed [COORD_W-1:0]  key_x;
  logic signed [COORD_W-1:0]  key_y;
  logic signed [COORD_W-1:0]  key_z;
  logic [ID_W-1:0]            chunk_id;

  modport source (output valid, func, key_x, key_y, key_z, chunk_id, input ready);
  modport sink (input valid, func, key_x, key_y, key_z, chunk_id, output ready);
endinterface

// ===== design/chtlp_rsp_if.sv =====
interface chtlp_rsp_if import chtlp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [SLOT_W-1:0]    slot_index;
  logic [ID_W-1:0]      found_id;
  logic [TOTAL_W-1:0]   entry_total;

  modport source (output valid, status, slot_index, found_id, entry_total, input ready);
  modport sink (input valid, status, slot_index, found_id, entry_total, output ready);
endinterface

// ===== design/chtlp_ram.sv =====
module chtlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/chtlp_hash.sv =====
// Home slot unit: forms the 32-bit wrapped weighted sum on start, then reduces
// it modulo SLOTS by a reciprocal multiplication spread over four register
// stages. The home slot is valid when done is high.
module chtlp_hash import chtlp_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [KEY_W-1:0]         key,
  output logic                     done,
  output logic [$clog2(SLOTS)-1:0] home
);

  localparam int IW = $clog2(SLOTS);
  // With RECIP = ceil(2^(32+IW) / SLOTS), the quotient of any 32-bit sum by
  // SLOTS is exactly (sum * RECIP) >> (32 + IW). RECIP fits in 33 bits, so the
  // product is formed from a 17-bit upper half and a 16-bit lower half.
  localparam int SH = 32 + IW;
  localparam longint unsigned RECIP =
      ((64'd1 << SH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
  localparam logic [16:0] RECIP_HI = 17'(RECIP >> 16);
  localparam logic [15:0] RECIP_LO = 16'(RECIP);
  localparam logic [31:0] DIVISOR  = 32'(SLOTS);

  logic [31:0]   sx, sy, sz, sum_now;
  logic [31:0]   sum;
  logic [48:0]   prod_hi;
  logic [47:0]   prod_lo;
  logic [64:0]   prod_full;
  logic [31:0]   quot;
  logic [31:0]   back;
  logic [IW-1:0] rem;
  logic [3:0]    stage;

  assign sx = {{(32-COORD_W){key[KEY_W-1]}}, key[KEY_W-1 -: COORD_W]};
  assign sy = {{(32-COORD_W){key[2*COORD_W-1]}}, key[2*COORD_W-1 -: COORD_W]};
  assign sz = {{(32-COORD_W){key[COORD_W-1]}}, key[COORD_W-1:0]};
  assign sum_now = 32'(sx * HASH_MUL_X) + 32'(sy * HASH_MUL_Y) + 32'(sz * HASH_MUL_Z);

  assign prod_full = {prod_hi, 16'b0} + 65'(prod_lo);
  assign home      = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
      done  <= 1'b0;
    end else begin
      stage <= {stage[2:0], start};
      done  <= stage[3];
    end
  end

  // The sum is held from start until the remainder is formed; the later
  // stages simply follow it.
  always_ff @(posedge clk) begin
    if (start) begin
      sum <= sum_now;
    end
    prod_hi <= 49'(sum) * 49'(RECIP_HI);
    prod_lo <= 48'(sum) * 48'(RECIP_LO);
    quot    <= 32'(prod_full >> SH);
    back    <= quot * DIVISOR;
    rem     <= IW'(sum - back);
  end

endmodule

// ===== design/coord_hash_table_linear_probe_unit.sv =====
// Coordinate-keyed open-addressing hash table with linear probing. Each request
// word is a lookup, an insert or a remove of a signed 3D key, and each gives one
// response word. After reset the unit sweeps the slot memory once, one slot per
// cycle, with the request side held not ready. A request is accepted in the
// idle state, then passes through the home-slot unit (the modulo reduction is a
// reciprocal multiplication over four register stages), a read and a check of
// each probed slot through the registered-read slot memory, and a done state
// that posts the response once the response register is free, then returns to
// the idle state for the next request. A remove also reads and lifts out each
// entry of the rest of its cluster, and then reinserts each such entry by
// reading it back from the cluster buffer, hashing it again and following its
// own probe chain. The next request is accepted once the previous response is
// posted, even while that response still waits to be taken.
module coord_hash_table_linear_probe_unit import chtlp_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input logic         clk,
  input logic         rst,
  chtlp_req_if.sink   req,
  chtlp_rsp_if.source rsp
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int EW = 1 + KEY_W + ID_W;   // used flag, key, payload
  localparam int BW = KEY_W + ID_W;

  localparam logic [3:0] S_CLR      = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_HASH     = 4'd2;
  localparam logic [3:0] S_PRB_RD   = 4'd3;
  localparam logic [3:0] S_PRB_CHK  = 4'd4;
  localparam logic [3:0] S_SCN_RD   = 4'd5;
  localparam logic [3:0] S_SCN_CHK  = 4'd6;
  localparam logic [3:0] S_BUF_RD   = 4'd7;
  localparam logic [3:0] S_BUF_WAIT = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  logic [3:0]          state;
  logic [IW-1:0]       idx;
  logic [IW-1:0]       home;
  logic [IW-1:0]       cnt;
  logic [IW-1:0]       k;
  logic [CW-1:0]       count;
  logic [FUNC_W-1:0]   cur_func;
  logic [KEY_W-1:0]    cur_key;
  logic [ID_W-1:0]     cur_id;
  logic                storing;
  logic                reinsert;
  logic [STATUS_W-1:0] res_status;
  logic [IW-1:0]       res_slot;
  logic [ID_W-1:0]     res_found;

  logic [IW-1:0]       nxt;
  logic                accept;
  logic                room;

  // Slot memory: one word per slot holding the used flag, key and payload.
  logic                tbl_we;
  logic [IW-1:0]       tbl_waddr;
  logic [EW-1:0]       tbl_wdata;
  logic [EW-1:0]       tbl_rdata;
  logic                ent_used;
  logic [KEY_W-1:0]    ent_key;
  logic [ID_W-1:0]     ent_id;

  // Cluster buffer: entries lifted out by a remove, in slot order.
  logic                buf_we;
  logic [BW-1:0]       buf_rdata;

  logic                hash_start;
  logic [KEY_W-1:0]    hash_key;
  logic                hash_done;
  logic [IW-1:0]       hash_home;

  logic [CW:0]         count_inc;
  logic [SLOT_W+IW-1:0] slot_wide;
  logic [TOTAL_W+CW-1:0] total_wide;

  assign nxt      = (idx == LAST) ? '0 : idx + IW'(1);
  assign accept   = req.valid && req.ready;
  assign ent_used = tbl_rdata[EW-1];
  assign ent_key  = tbl_rdata[EW-2 -: KEY_W];
  assign ent_id   = tbl_rdata[ID_W-1:0];
  assign count_inc = {1'b0, count} + (CW+1)'(1);
  assign room     = count_inc < (CW+1)'(SLOTS);

  assign req.ready = (state == S_IDLE);

  chtlp_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (idx),
    .rdata (tbl_rdata)
  );

  chtlp_ram #(.WIDTH(BW), .DEPTH(SLOTS)) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (cnt),
    .wdata ({ent_key, ent_id}),
    .raddr (k),
    .rdata (buf_rdata)
  );

  // The hash takes the request key on accept and a buffered key on reinsert.
  assign hash_start = accept || (state == S_BUF_WAIT);
  assign hash_key   = (state == S_BUF_WAIT) ? buf_rdata[BW-1 -: KEY_W]
                                            : {req.key_x, req.key_y, req.key_z};

  chtlp_hash #(.SLOTS(SLOTS)) u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (hash_key),
    .done  (hash_done),
    .home  (hash_home)
  );

  // Memory writes: the sweep after reset, placing an entry, and clearing a slot
  // when its entry is removed or lifted into the cluster buffer.
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = idx;
    tbl_wdata = {1'b0, cur_key, cur_id};
    buf_we    = 1'b0;
    unique case (state)
      S_CLR: begin
        tbl_we = 1'b1;
      end
      S_PRB_CHK: begin
        if (storing && !ent_used) begin
          tbl_we    = 1'b1;
          tbl_wdata = {1'b1, cur_key, cur_id};
        end else if (!storing && ent_used && ent_key == cur_key &&
                     cur_func == FUNC_REMOVE) begin
          tbl_we = 1'b1;
        end
      end
      S_SCN_CHK: begin
        if (ent_used) begin
          tbl_we = 1'b1;
          buf_we = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      idx      <= '0;
      count    <= '0;
      storing  <= 1'b0;
      reinsert <= 1'b0;
    end else begin
      unique case (state)
        S_CLR: begin
          idx <= nxt;
          if (idx == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cur_func   <= req.func;
            cur_key    <= {req.key_x, req.key_y, req.key_z};
            cur_id     <= req.chunk_id;
            res_status <= ST_MISS;
            res_slot   <= '0;
            res_found  <= '0;
            reinsert   <= 1'b0;
            state      <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            idx  <= hash_home;
            home <= hash_home;
            if (reinsert) begin
              storing <= 1'b1;
              state   <= S_PRB_RD;
            end else begin
              unique case (cur_func)
                FUNC_LOOKUP, FUNC_REMOVE: begin
                  storing <= 1'b0;
                  state   <= S_PRB_RD;
                end
                FUNC_INSERT: begin
                  storing <= 1'b1;
                  if (room) begin
                    state <= S_PRB_RD;
                  end else begin
                    res_status <= ST_FULL;
                    state      <= S_DONE;
                  end
                end
                default: begin
                  state <= S_DONE;
                end
              endcase
            end
          end
        end
        S_PRB_RD: begin
          state <= S_PRB_CHK;
        end
        S_PRB_CHK: begin
          if (storing) begin
            if (ent_used) begin
              idx   <= nxt;
              state <= S_PRB_RD;
            end else begin
              count <= CW'(count_inc);
              if (reinsert) begin
                k <= k + IW'(1);
                if (k + IW'(1) == cnt) begin
                  state <= S_DONE;
                end else begin
                  state <= S_BUF_RD;
                end
              end else begin
                res_status <= ST_OK;
                res_slot   <= idx;
                state      <= S_DONE;
              end
            end
          end else if (!ent_used) begin
            state <= S_DONE;
          end else if (ent_key == cur_key) begin
            res_status <= ST_OK;
            res_slot   <= idx;
            res_found  <= ent_id;
            if (cur_func == FUNC_REMOVE) begin
              count <= count - CW'(1);
              idx   <= nxt;
              cnt   <= '0;
              state <= S_SCN_RD;
            end else begin
              state <= S_DONE;
            end
          end else begin
            idx <= nxt;
            if (nxt == home) begin
              state <= S_DONE;
            end else begin
              state <= S_PRB_RD;
            end
          end
        end
        S_SCN_RD: begin
          state <= S_SCN_CHK;
        end
        S_SCN_CHK: begin
          if (ent_used) begin
            cnt   <= cnt + IW'(1);
            count <= count - CW'(1);
            idx   <= nxt;
            state <= S_SCN_RD;
          end else if (cnt == '0) begin
            state <= S_DONE;
          end else begin
            k        <= '0;
            reinsert <= 1'b1;
            state    <= S_BUF_RD;
          end
        end
        S_BUF_RD: begin
          state <= S_BUF_WAIT;
        end
        S_BUF_WAIT: begin
          cur_key <= buf_rdata[BW-1 -: KEY_W];
          cur_id  <= buf_rdata[ID_W-1:0];
          state   <= S_HASH;
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Response register: loaded at the end of an operation, held until taken.
  assign slot_wide  = {{SLOT_W{1'b0}}, res_slot};
  assign total_wide = {{TOTAL_W{1'b0}}, count};

  logic                rsp_valid;
  logic [STATUS_W-1:0] rsp_status;
  logic [SLOT_W-1:0]   rsp_slot;
  logic [ID_W-1:0]     rsp_found;
  logic [TOTAL_W-1:0]  rsp_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && (!rsp_valid || rsp.ready)) begin
      rsp_valid  <= 1'b1;
      rsp_status <= res_status;
      rsp_slot   <= slot_wide[SLOT_W-1:0];
      rsp_found  <= res_found;
      rsp_total  <= total_wide[TOTAL_W-1:0];
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.slot_index  = rsp_slot;
  assign rsp.found_id    = rsp_found;
  assign rsp.entry_total = rsp_total;

endmodule

// ===== design/chtlp_checker.sv =====
module chtlp_checker import chtlp_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] rsp_status,
  input logic [SLOT_W-1:0]   rsp_slot,
  input logic [ID_W-1:0]     rsp_found
);

  // A waiting response word stays valid and keeps its status and slot until it is taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot))
    else $error("response changed while stalled");

  // The unit works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while busy");

  // A refused or missed operation reports no slot and no payload.
  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_MISS || rsp_status == ST_FULL) |->
      rsp_slot == '0 && rsp_found == '0)
    else $error("miss or full response carries data");

endmodule

bind coord_hash_table_linear_probe_unit chtlp_checker u_chtlp_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_slot   (rsp.slot_index),
  .rsp_found  (rsp.found_id)
);
